### src/sample_history_window_min_max_macros.svh
// Assertion macros shared by the sample history window block.
`ifndef SAMPLE_HISTORY_WINDOW_MIN_MAX_MACROS_SVH
`define SAMPLE_HISTORY_WINDOW_MIN_MAX_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold in the same cycle as its condition.
`define SHWMM_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("shwmm check failed");

// The property must hold in the cycle after its condition.
`define SHWMM_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("shwmm check failed");

`else

`define SHWMM_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define SHWMM_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

### src/shwmm_pkg.sv
package shwmm_pkg;

   // Stream widths.
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 56;

   // Field widths.
   localparam int ACTION_W  = 2;
   localparam int SAMPLE_W  = 16;
   localparam int BACK_W    = 6;
   localparam int WCOUNT_W  = 7;
   localparam int HELD_W    = 7;

   // Action codes; the unused code behaves as a query.
   localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [SAMPLE_W-1:0] sample;
      logic [BACK_W-1:0]   back_index;
      logic [WCOUNT_W-1:0] window_count;
   } req_item_type;

   typedef struct packed {
      logic [HELD_W-1:0]   held_count;
      logic [SAMPLE_W-1:0] sample_back;
      logic [SAMPLE_W-1:0] window_min;
      logic [SAMPLE_W-1:0] window_max;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_BACK,
      ST_WALK,
      ST_DONE
   } state_type;

   // Tag of the memory read whose data returns in the next cycle.
   typedef enum logic [1:0] {
      RD_NONE,
      RD_BACK,
      RD_WALK
   } rd_kind_type;

endpackage

### src/sample_history_window_min_max.sv
// Sample history with windowed minimum and maximum. Each request pushes a
// sample, clears the history, or only queries, and returns one response with
// the held count, the sample back_index steps behind the newest, and the
// minimum and maximum over the newest window_count samples. Requests are taken
// one at a time: a request with a window span of S samples (S is window_count,
// or the held count when window_count is 0 or larger) occupies the block from
// its transfer while its S samples are walked until its response is loaded.
// The walk is paced by the single read port of the sample memory, which
// delivers one stored sample per cycle to the min/max walk. The response sits
// in an output register, so the next request can be taken while the previous
// response still waits.
module sample_history_window_min_max #(
   parameter int DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // sample[15:0], back_index[21:16], window_count[28:22], zero pad to 32 bits
   input  logic [shwmm_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // action[1:0]
   input  logic [shwmm_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // held_count[6:0], sample_back[22:7], window_min[38:23], window_max[54:39],
   // zero pad to 56 bits
   output logic [shwmm_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   import shwmm_pkg::*;

   req_item_type item;
   rsp_item_type res;
   logic         res_valid;
   logic         slot_free;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff, rsp_data_in;

   // Unpack the request transfer.
   always_comb begin
      item.action       = req_tuser[ACTION_W-1:0];
      item.sample       = req_tdata[15:0];
      item.back_index   = req_tdata[21:16];
      item.window_count = req_tdata[28:22];
   end

   shwmm_walker #(
      .DEPTH (DEPTH)
   ) u_walker (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .item       (item),
      .res_valid  (res_valid),
      .res_ready  (slot_free),
      .res        (res)
   );

   // Output register: loads when empty or being emptied in this cycle.
   always_comb begin
      slot_free    = !rsp_valid_ff || rsp_tready;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (slot_free) begin
         rsp_valid_in = res_valid;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // Pack the response transfer.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0,
                        rsp_data_ff.window_max,
                        rsp_data_ff.window_min,
                        rsp_data_ff.sample_back,
                        rsp_data_ff.held_count};

endmodule

### src/shwmm_sample_ram.sv
module shwmm_sample_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/shwmm_walker.sv
`include "sample_history_window_min_max_macros.svh"

module shwmm_walker #(
   parameter int DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   output logic                   item_ready,
   input  shwmm_pkg::req_item_type item,
   output logic                   res_valid,
   input  logic                   res_ready,
   output shwmm_pkg::rsp_item_type res
);

   import shwmm_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > WCOUNT_W) ? CW : WCOUNT_W;
   localparam int AW = XW + 1;

   state_type           state_ff, state_in;
   rd_kind_type         rd_kind_ff, rd_kind_in;

   logic [ACTION_W-1:0] act_ff, act_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [BACK_W-1:0]   back_ff, back_in;
   logic [WCOUNT_W-1:0] wcount_ff, wcount_in;

   logic [IW-1:0]       wp_ff, wp_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic [CW-1:0]       remain_ff, remain_in;
   logic [IW-1:0]       ptr_ff, ptr_in;
   logic                first_ff, first_in;
   logic [SAMPLE_W-1:0] min_ff, min_in;
   logic [SAMPLE_W-1:0] max_ff, max_in;
   logic [SAMPLE_W-1:0] sback_ff, sback_in;

   logic                wr_en;
   logic                rd_en;
   logic [IW-1:0]       rd_addr;
   logic [SAMPLE_W-1:0] rd_data;

   logic [XW-1:0]       fill_x;
   logic [XW-1:0]       back_x;
   logic [XW-1:0]       wcount_x;
   logic                back_hit;
   logic [CW-1:0]       span;
   logic [AW-1:0]       back_sum;
   logic [IW-1:0]       back_addr;
   logic [IW-1:0]       newest_addr;

   shwmm_sample_ram #(
      .DEPTH (DEPTH),
      .WIDTH (SAMPLE_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (sample_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Span of the window and slot of the requested back sample.
   always_comb begin
      fill_x      = XW'(fill_ff);
      back_x      = XW'(back_ff);
      wcount_x    = XW'(wcount_ff);
      back_hit    = back_x < fill_x;
      span        = ((wcount_x == '0) || (wcount_x > fill_x)) ? fill_ff : wcount_x[CW-1:0];
      back_sum    = AW'(wp_ff) + AW'(DEPTH - 1) - AW'(back_ff);
      if (back_sum >= AW'(DEPTH)) begin
         back_sum = back_sum - AW'(DEPTH);
      end
      back_addr   = back_sum[IW-1:0];
      newest_addr = (wp_ff == '0) ? IW'(DEPTH - 1) : wp_ff - IW'(1);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: state_in = ST_BACK;
         ST_BACK: state_in = ST_WALK;
         ST_WALK: begin
            if (remain_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      act_in     = act_ff;
      sample_in  = sample_ff;
      back_in    = back_ff;
      wcount_in  = wcount_ff;
      wp_in      = wp_ff;
      fill_in    = fill_ff;
      remain_in  = remain_ff;
      ptr_in     = ptr_ff;
      first_in   = first_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      sback_in   = sback_ff;
      rd_kind_in = RD_NONE;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = ptr_ff;
      item_ready = 1'b0;
      res_valid  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               act_in    = item.action;
               sample_in = item.sample;
               back_in   = item.back_index;
               wcount_in = item.window_count;
            end
         end
         ST_EXEC: begin
            case (act_ff)
               ACT_PUSH: begin
                  wr_en = 1'b1;
                  wp_in = (wp_ff == IW'(DEPTH - 1)) ? '0 : wp_ff + IW'(1);
                  if (fill_ff < CW'(DEPTH)) begin
                     fill_in = fill_ff + CW'(1);
                  end
               end
               ACT_CLEAR: begin
                  wp_in   = '0;
                  fill_in = '0;
               end
               default: begin
               end
            endcase
         end
         ST_BACK: begin
            rd_en      = back_hit;
            rd_addr    = back_addr;
            rd_kind_in = back_hit ? RD_BACK : RD_NONE;
            sback_in   = '0;
            remain_in  = span;
            ptr_in     = newest_addr;
            first_in   = 1'b1;
            min_in     = '0;
            max_in     = '0;
         end
         ST_WALK: begin
            if (remain_ff != '0) begin
               rd_en      = 1'b1;
               rd_addr    = ptr_ff;
               rd_kind_in = RD_WALK;
               ptr_in     = (ptr_ff == '0) ? IW'(DEPTH - 1) : ptr_ff - IW'(1);
               remain_in  = remain_ff - CW'(1);
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
         end
         default: begin
         end
      endcase

      // Fold in the data of the read issued in the previous cycle.
      case (rd_kind_ff)
         RD_BACK: sback_in = rd_data;
         RD_WALK: begin
            first_in = 1'b0;
            if (first_ff || (rd_data < min_ff)) begin
               min_in = rd_data;
            end
            if (first_ff || (rd_data > max_ff)) begin
               max_in = rd_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      res.held_count  = fill_x[HELD_W-1:0];
      res.sample_back = sback_ff;
      res.window_min  = min_ff;
      res.window_max  = max_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_kind_ff <= RD_NONE;
         wp_ff      <= '0;
         fill_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         rd_kind_ff <= rd_kind_in;
         wp_ff      <= wp_in;
         fill_ff    <= fill_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      sample_ff <= sample_in;
      back_ff   <= back_in;
      wcount_ff <= wcount_in;
      remain_ff <= remain_in;
      ptr_ff    <= ptr_in;
      first_ff  <= first_in;
      min_ff    <= min_in;
      max_ff    <= max_in;
      sback_ff  <= sback_in;
   end

   `SHWMM_ASSERT_IMPLIES(a_fill_bound, clock, reset, 1'b1, fill_ff <= CW'(DEPTH))
   `SHWMM_ASSERT_IMPLIES(a_wp_bound, clock, reset, 1'b1, wp_ff <= IW'(DEPTH - 1))
   `SHWMM_ASSERT_IMPLIES(a_walk_span, clock, reset, state_ff == ST_WALK, remain_ff <= fill_ff)
   `SHWMM_ASSERT_NEXT(a_read_tag, clock, reset, rd_en, rd_kind_ff != RD_NONE)
   `SHWMM_ASSERT_IMPLIES(a_done_drained, clock, reset, state_ff == ST_DONE, rd_kind_ff == RD_NONE)

endmodule
